@@ rtl/animation_frame_sequencer_assert.svh @@
// Assertion macros for the animation frame sequencer.
`ifndef ANIMATION_FRAME_SEQUENCER_ASSERT_SVH
`define ANIMATION_FRAME_SEQUENCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define AFS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afs assertion failed");
// Next-cycle implication, disabled during reset.
`define AFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afs assertion failed");
`else
`define AFS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define AFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/afs_pkg.sv @@
// Types, constants and microcode table of the animation frame sequencer.
`default_nettype none
package afs_pkg;

  localparam int NUM_CLIPS  = 16;
  localparam int FRAME_BITS = 10;
  localparam int CLIP_W     = 4;
  localparam int CLIP_AW    = $clog2(NUM_CLIPS);
  localparam int SPEED_W    = 12;
  localparam int TIME_W     = 16;
  localparam int RATE_W     = 16;
  localparam int TICK_W     = 16;
  localparam int PHASE_W    = 18;
  localparam int BLEND_W    = 17;
  localparam int ENTRY_W    = FRAME_BITS + RATE_W;
  localparam int PROD_RS_W  = RATE_W + SPEED_W;
  localparam int PROD_W     = PROD_RS_W + TICK_W;
  localparam int INC_W      = PROD_W - 32;
  localparam int DIV_W      = TICK_W + 8;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int PADDR_W    = 3;
  localparam int PC_W       = 4;

  localparam logic [BLEND_W-1:0] ONE_Q16    = BLEND_W'(65536);
  localparam logic [PHASE_W-1:0] PHASE_MAX  = '1;
  localparam logic [TICK_W-1:0]  TICK_RESET = TICK_W'(1092);
  localparam logic [SPEED_W-1:0] SPEED_ONE  = SPEED_W'(256);

  // Register index of tick_seconds
  localparam logic [PADDR_W-3:0] REG_TICK = '0;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_LOAD = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  command;
    logic [CLIP_W-1:0]     clip_index;
    logic [SPEED_W-1:0]    speed_scale;
    logic [TIME_W-1:0]     blend_time;
    logic [FRAME_BITS-1:0] frame_count;
    logic [RATE_W-1:0]     frame_rate;
  } cmd_word_t;

  typedef struct packed {
    logic                  playing;
    logic [CLIP_W-1:0]     cur_clip;
    logic [FRAME_BITS-1:0] cur_frame;
    logic [PHASE_W-1:0]    cur_phase;
    logic                  next_active;
    logic [CLIP_W-1:0]     next_clip;
    logic [FRAME_BITS-1:0] next_frame;
    logic [PHASE_W-1:0]    next_phase;
    logic [BLEND_W-1:0]    blend_progress;
  } res_word_t;

  // Datapath operations of one microcode step
  typedef enum logic [3:0] {
    U_WAIT,
    U_LOAD,
    U_DIV_INIT,
    U_DIV_STEP,
    U_PLAY_SET,
    U_READ,
    U_MUL_RS,
    U_MUL_T,
    U_ADV,
    U_BLEND,
    U_EMIT
  } uop_t;

  // Sequencing of the step counter
  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_DIV_LOOP,
    J_SKIP_PEND,
    J_HOLD_OUT
  } jump_t;

  typedef enum logic {
    SIDE_ACT,
    SIDE_PEND
  } side_t;

  typedef struct packed {
    uop_t            op;
    side_t           side;
    jump_t           jump;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_LOAD     = 4'd1;
  localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd2;
  localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd3;
  localparam logic [PC_W-1:0] PC_PLAY_SET = 4'd4;
  localparam logic [PC_W-1:0] PC_TICK     = 4'd5;
  localparam logic [PC_W-1:0] PC_ACT_MRS  = 4'd6;
  localparam logic [PC_W-1:0] PC_ACT_MT   = 4'd7;
  localparam logic [PC_W-1:0] PC_ACT_ADV  = 4'd8;
  localparam logic [PC_W-1:0] PC_BLEND    = 4'd9;
  localparam logic [PC_W-1:0] PC_PND_RD   = 4'd10;
  localparam logic [PC_W-1:0] PC_PND_MRS  = 4'd11;
  localparam logic [PC_W-1:0] PC_PND_MT   = 4'd12;
  localparam logic [PC_W-1:0] PC_PND_ADV  = 4'd13;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd14;

  // Control store: one control word per step
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      PC_IDLE:     c = '{U_WAIT,     SIDE_ACT,  J_DISPATCH,  PC_IDLE};
      PC_LOAD:     c = '{U_LOAD,     SIDE_ACT,  J_GOTO,      PC_EMIT};
      PC_DIV_INIT: c = '{U_DIV_INIT, SIDE_ACT,  J_NEXT,      PC_IDLE};
      PC_DIV_STEP: c = '{U_DIV_STEP, SIDE_ACT,  J_DIV_LOOP,  PC_DIV_STEP};
      PC_PLAY_SET: c = '{U_PLAY_SET, SIDE_ACT,  J_GOTO,      PC_EMIT};
      PC_TICK:     c = '{U_READ,     SIDE_ACT,  J_NEXT,      PC_IDLE};
      PC_ACT_MRS:  c = '{U_MUL_RS,   SIDE_ACT,  J_NEXT,      PC_IDLE};
      PC_ACT_MT:   c = '{U_MUL_T,    SIDE_ACT,  J_NEXT,      PC_IDLE};
      PC_ACT_ADV:  c = '{U_ADV,      SIDE_ACT,  J_NEXT,      PC_IDLE};
      PC_BLEND:    c = '{U_BLEND,    SIDE_PEND, J_SKIP_PEND, PC_EMIT};
      PC_PND_RD:   c = '{U_READ,     SIDE_PEND, J_NEXT,      PC_IDLE};
      PC_PND_MRS:  c = '{U_MUL_RS,   SIDE_PEND, J_NEXT,      PC_IDLE};
      PC_PND_MT:   c = '{U_MUL_T,    SIDE_PEND, J_NEXT,      PC_IDLE};
      PC_PND_ADV:  c = '{U_ADV,      SIDE_PEND, J_NEXT,      PC_IDLE};
      PC_EMIT:     c = '{U_EMIT,     SIDE_ACT,  J_HOLD_OUT,  PC_IDLE};
      default:     c = '{U_WAIT,     SIDE_ACT,  J_GOTO,      PC_IDLE};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/afs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module afs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/animation_frame_sequencer.sv @@
// Top level of the animation frame sequencer: microcode sequencer and datapath.
`default_nettype none
`include "animation_frame_sequencer_assert.svh"
// Plays a current clip and cross-fades in a pending one. One command word is
// taken at a time and each gives one result word showing the state after it.
// A load writes the clip table. A play works out the blend step in a 24-step
// restoring divider, one quotient bit a cycle. A tick does one table read and
// two registered multiplies per clip advanced, both clips sharing the
// multiplier; it also advances the pending clip while one blends in, but not
// on the tick that ends a blend. A tick before any play and a no-op only give
// their result word. The result register frees the input side: a
// new word is taken while the last result waits, and the final step holds
// only while a result is still stalled.
// The clip tables have no reset; entries must be loaded before they are played.
module animation_frame_sequencer
  import afs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire cmd_word_t          cmd_word,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output res_word_t               res_word
);

  logic [PC_W-1:0]       pc;
  logic [PC_W-1:0]       pc_next;
  ctrl_t                 cw;
  logic                  cmd_accept;
  cmd_word_t             cmd_q;
  logic [TICK_W-1:0]     tick_seconds;

  logic                  play_flag;
  logic [CLIP_W-1:0]     active_clip;
  logic [FRAME_BITS-1:0] active_frame;
  logic [SPEED_W-1:0]    active_speed;
  logic [PHASE_W-1:0]    active_phase;
  logic                  pending_valid;
  logic [CLIP_W-1:0]     pending_clip;
  logic [FRAME_BITS-1:0] pending_frame;
  logic [SPEED_W-1:0]    pending_speed;
  logic [PHASE_W-1:0]    pending_phase;
  logic [BLEND_W-1:0]    blend_acc;
  logic [BLEND_W-1:0]    blend_step;

  logic [CLIP_W-1:0]     rd_clip;
  logic [ENTRY_W-1:0]    tbl_rdata;
  logic [SPEED_W-1:0]    speed_sel;
  logic [PROD_RS_W-1:0]  prod_rs;
  logic [PROD_W-1:0]     prod_full;
  logic [INC_W-1:0]      inc_q;
  logic [FRAME_BITS-1:0] count_q;

  logic [PHASE_W-1:0]    phase_sel;
  logic [FRAME_BITS-1:0] frame_sel;
  logic [PHASE_W:0]      phase_sum;
  logic [PHASE_W-1:0]    phase_sat;
  logic                  frame_step;
  logic [FRAME_BITS:0]   frame_inc;
  logic [FRAME_BITS-1:0] frame_wrap;
  logic [PHASE_W-1:0]    phase_new;
  logic [FRAME_BITS-1:0] frame_new;

  logic [BLEND_W-1:0]    blend_sum;
  logic                  blend_done;

  logic [DIV_W-1:0]      div_dq;
  logic [TIME_W-1:0]     div_rem;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [TIME_W:0]       div_trial;
  logic                  div_ge;
  logic [TIME_W:0]       div_diff;
  logic [BLEND_W-1:0]    step_val;

  logic                  cfg_write;
  logic                  clip_ok;

  // Decode the current step
  assign cw         = ucode(pc);
  assign cmd_stall  = (pc != PC_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign clip_ok    = (32'(cmd_word.clip_index) < NUM_CLIPS);

  // Advance the step counter
  always_comb begin
    pc_next = pc;
    case (cw.jump)
      J_NEXT: begin
        pc_next = pc + PC_W'(1);
      end
      J_GOTO: begin
        pc_next = cw.target;
      end
      J_DISPATCH: begin
        if (cmd_accept) begin
          case (cmd_word.command)
            CMD_LOAD: pc_next = clip_ok ? PC_LOAD : PC_EMIT;
            CMD_PLAY: pc_next = clip_ok ? PC_DIV_INIT : PC_EMIT;
            CMD_TICK: pc_next = play_flag ? PC_TICK : PC_EMIT;
            default:  pc_next = PC_EMIT;
          endcase
        end
      end
      J_DIV_LOOP: begin
        pc_next = (div_cnt == DIV_CNT_W'(DIV_W - 1)) ? pc + PC_W'(1) : cw.target;
      end
      J_SKIP_PEND: begin
        pc_next = (!pending_valid || blend_done) ? cw.target : pc + PC_W'(1);
      end
      J_HOLD_OUT: begin
        pc_next = (res_valid && res_stall) ? pc : cw.target;
      end
      default: begin
        pc_next = PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Hold the accepted command word
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      cmd_q <= cmd_word;
    end
  end

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[PADDR_W-1:2] == REG_TICK) ? 32'(tick_seconds) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_seconds <= TICK_RESET;
    end else if (cfg_write && paddr[PADDR_W-1:2] == REG_TICK) begin
      tick_seconds <= pwdata[TICK_W-1:0];
    end
  end

  // Clip table: frame count over frame rate
  assign rd_clip = (cw.side == SIDE_PEND) ? pending_clip : active_clip;

  afs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CLIPS)
  ) u_clip_table (
    .clk   (clk),
    .we    (cw.op == U_LOAD),
    .waddr (cmd_q.clip_index[CLIP_AW-1:0]),
    .wdata ({cmd_q.frame_count, cmd_q.frame_rate}),
    .raddr (rd_clip[CLIP_AW-1:0]),
    .rdata (tbl_rdata)
  );

  // Rate times speed, then times tick length
  assign speed_sel = (cw.side == SIDE_PEND) ? pending_speed : active_speed;
  assign prod_full = PROD_W'(prod_rs) * PROD_W'(tick_seconds);

  always_ff @(posedge clk) begin
    if (cw.op == U_MUL_RS) begin
      prod_rs <= PROD_RS_W'(tbl_rdata[RATE_W-1:0]) * PROD_RS_W'(speed_sel);
      count_q <= tbl_rdata[ENTRY_W-1:RATE_W];
    end
    if (cw.op == U_MUL_T) begin
      inc_q <= prod_full[PROD_W-1:32];
    end
  end

  // Phase advance with saturation and frame wrap
  assign phase_sel = (cw.side == SIDE_PEND) ? pending_phase : active_phase;
  assign frame_sel = (cw.side == SIDE_PEND) ? pending_frame : active_frame;

  always_comb begin
    phase_sum  = {1'b0, phase_sel} + (PHASE_W + 1)'(inc_q);
    phase_sat  = (phase_sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : phase_sum[PHASE_W-1:0];
    frame_step = (phase_sat >= PHASE_W'(ONE_Q16));
    frame_inc  = {1'b0, frame_sel} + (FRAME_BITS + 1)'(1);
    if (count_q < FRAME_BITS'(2)) begin
      frame_wrap = '0;
    end else if (frame_inc >= (FRAME_BITS + 1)'(count_q - FRAME_BITS'(1))) begin
      frame_wrap = '0;
    end else begin
      frame_wrap = frame_inc[FRAME_BITS-1:0];
    end
    phase_new = frame_step ? phase_sat - PHASE_W'(ONE_Q16) : phase_sat;
    frame_new = frame_step ? frame_wrap : frame_sel;
  end

  // Blend progress
  assign blend_sum  = blend_acc + blend_step;
  assign blend_done = blend_sum[BLEND_W-1];

  // Restoring divider: tick length times 256 over blend time
  always_comb begin
    div_trial = {div_rem, div_dq[DIV_W-1]};
    div_ge    = (div_trial >= {1'b0, cmd_q.blend_time});
    div_diff  = div_trial - {1'b0, cmd_q.blend_time};
    if (cmd_q.blend_time == '0) begin
      step_val = ONE_Q16;
    end else if (div_dq == '0) begin
      step_val = BLEND_W'(1);
    end else if (div_dq > DIV_W'(ONE_Q16)) begin
      step_val = ONE_Q16;
    end else begin
      step_val = div_dq[BLEND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == U_DIV_INIT) begin
      div_dq  <= {tick_seconds, 8'd0};
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cw.op == U_DIV_STEP) begin
      div_dq  <= {div_dq[DIV_W-2:0], div_ge};
      div_rem <= div_ge ? div_diff[TIME_W-1:0] : div_trial[TIME_W-1:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // Playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      play_flag     <= 1'b0;
      active_clip   <= '0;
      active_frame  <= '0;
      active_speed  <= SPEED_ONE;
      active_phase  <= '0;
      pending_valid <= 1'b0;
      pending_clip  <= '0;
      pending_frame <= '0;
      pending_speed <= SPEED_ONE;
      pending_phase <= '0;
      blend_acc     <= '0;
      blend_step    <= '0;
    end else begin
      case (cw.op)
        U_PLAY_SET: begin
          play_flag     <= 1'b1;
          pending_valid <= 1'b1;
          pending_clip  <= cmd_q.clip_index;
          pending_speed <= cmd_q.speed_scale;
          blend_step    <= step_val;
        end
        U_ADV: begin
          if (cw.side == SIDE_PEND) begin
            pending_frame <= frame_new;
            pending_phase <= phase_new;
          end else begin
            active_frame <= frame_new;
            active_phase <= phase_new;
          end
        end
        U_BLEND: begin
          if (pending_valid) begin
            if (blend_done) begin
              // Promote the pending clip and clear the blend
              active_clip   <= pending_clip;
              active_frame  <= pending_frame;
              active_phase  <= pending_phase;
              active_speed  <= pending_speed;
              blend_acc     <= '0;
              pending_valid <= 1'b0;
              pending_frame <= '0;
              pending_phase <= '0;
            end else begin
              blend_acc <= blend_sum;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cw.op == U_EMIT && !(res_valid && res_stall)) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == U_EMIT && !(res_valid && res_stall)) begin
      res_word.playing        <= play_flag;
      res_word.cur_clip       <= active_clip;
      res_word.cur_frame      <= active_frame;
      res_word.cur_phase      <= active_phase;
      res_word.next_active    <= pending_valid;
      res_word.next_clip      <= pending_clip;
      res_word.next_frame     <= pending_frame;
      res_word.next_phase     <= pending_phase;
      res_word.blend_progress <= blend_acc;
    end
  end

  // Checks
  `AFS_ASSERT_IMPLIES(a_pend_needs_play, clk, rst, pending_valid, play_flag)
  `AFS_ASSERT_IMPLIES(a_step_range, clk, rst, pending_valid, blend_step != '0 && blend_step <= ONE_Q16)
  `AFS_ASSERT_IMPLIES(a_blend_below_one, clk, rst, 1'b1, blend_acc < ONE_Q16)
  `AFS_ASSERT_NEXT(a_one_word_in_flight, clk, rst, cmd_accept, cmd_stall)
  `AFS_ASSERT_IMPLIES(a_div_done, clk, rst, cw.op == U_PLAY_SET, div_cnt == DIV_CNT_W'(DIV_W))

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the animation frame sequencer.
`timescale 1ns / 1ps
module tb_top;
  import afs_pkg::*;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_COMB,
    RX_HEAVY
  } rx_mode_t;

  localparam int WORDS_PER_SETTING = 370;

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  cmd_word_t          cmd_word = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  res_word_t          res_word;

  animation_frame_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stimulus and expected playback state
  cmd_word_t cmd_fifo[$];
  res_word_t want_state[$];
  int        err_count = 0;

  // Playback state tracked alongside the block
  logic [TICK_W-1:0]     tick_len = TICK_RESET;
  logic                  play_seen = 1'b0;
  logic [CLIP_W-1:0]     act_clip = '0;
  logic [FRAME_BITS-1:0] act_frame = '0;
  logic [SPEED_W-1:0]    act_speed = SPEED_ONE;
  logic [PHASE_W-1:0]    act_phase = '0;
  logic                  pnd_on = 1'b0;
  logic [CLIP_W-1:0]     pnd_clip = '0;
  logic [FRAME_BITS-1:0] pnd_frame = '0;
  logic [SPEED_W-1:0]    pnd_speed = SPEED_ONE;
  logic [PHASE_W-1:0]    pnd_phase = '0;
  logic [BLEND_W-1:0]    blend_sum = '0;
  logic [BLEND_W-1:0]    blend_inc = '0;
  logic [FRAME_BITS-1:0] frames_tab[NUM_CLIPS];
  logic [RATE_W-1:0]     rate_tab[NUM_CLIPS];

  int n_load = 0, n_play = 0, n_tick = 0, n_other = 0;
  int n_frame_steps = 0, n_blends = 0, n_settings = 1;

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_error($sformatf("%s = %0d, expected %0d", name, got, want));
  endtask

  // Append one command word to the driver queue
  task automatic queue_cmd(input cmd_word_t w);
    cmd_fifo.insert(cmd_fifo.size(), w);
  endtask

  // Append one expected result word
  task automatic queue_state(input res_word_t r);
    want_state.insert(want_state.size(), r);
  endtask

  // Advance one clip by rate * speed * tick, stepping the frame on overflow
  task automatic advance_clip(input logic [CLIP_W-1:0] c, input logic [SPEED_W-1:0] spd,
                              inout logic [FRAME_BITS-1:0] fr,
                              inout logic [PHASE_W-1:0] ph);
    longint unsigned inc, sum;
    int unsigned cnt, nxt;
    cnt = frames_tab[c];
    inc = (64'(rate_tab[c]) * 64'(spd) * 64'(tick_len)) >> 32;
    sum = 64'(ph) + inc;
    if (sum > 64'(PHASE_MAX)) sum = 64'(PHASE_MAX);
    if (sum >= 64'(ONE_Q16)) begin
      nxt = 32'(fr) + 1;
      if (cnt < 2 || nxt >= cnt - 1) fr = '0;
      else fr = FRAME_BITS'(nxt);
      sum = sum - 64'(ONE_Q16);
      n_frame_steps++;
    end
    ph = PHASE_W'(sum);
  endtask

  // Apply one command word to the tracked state and give the state after it
  task automatic sequence_cmd(input cmd_word_t w, output res_word_t r);
    int unsigned step;
    case (w.command)
      CMD_LOAD: begin
        frames_tab[w.clip_index] = w.frame_count;
        rate_tab[w.clip_index] = w.frame_rate;
        n_load++;
      end
      CMD_PLAY: begin
        play_seen = 1'b1;
        pnd_on = 1'b1;
        pnd_clip = w.clip_index;
        pnd_speed = w.speed_scale;
        if (w.blend_time == '0) begin
          step = 32'(ONE_Q16);
        end else begin
          step = (32'(tick_len) * 256) / 32'(w.blend_time);
          if (step == 0) step = 1;
          if (step > 32'(ONE_Q16)) step = 32'(ONE_Q16);
        end
        blend_inc = BLEND_W'(step);
        n_play++;
      end
      CMD_TICK: begin
        n_tick++;
        if (play_seen) begin
          advance_clip(act_clip, act_speed, act_frame, act_phase);
          if (pnd_on) begin
            blend_sum = blend_sum + blend_inc;
            if (blend_sum >= ONE_Q16) begin
              // hand the pending clip over to the current slot
              act_clip = pnd_clip;
              act_frame = pnd_frame;
              act_phase = pnd_phase;
              act_speed = pnd_speed;
              blend_sum = '0;
              pnd_on = 1'b0;
              pnd_frame = '0;
              pnd_phase = '0;
              n_blends++;
            end else begin
              advance_clip(pnd_clip, pnd_speed, pnd_frame, pnd_phase);
            end
          end
        end
      end
      default: n_other++;
    endcase
    r.playing = play_seen;
    r.cur_clip = act_clip;
    r.cur_frame = act_frame;
    r.cur_phase = act_phase;
    r.next_active = pnd_on;
    r.next_clip = pnd_clip;
    r.next_frame = pnd_frame;
    r.next_phase = pnd_phase;
    r.blend_progress = blend_sum;
  endtask

  // Predict on every accepted command word, check every accepted result word
  always @(posedge clk) begin
    res_word_t r;
    if (!rst) begin
      if (res_valid === 1'b1 && !res_stall) begin
        if (want_state.size() == 0) begin
          report_error("result word with no command outstanding");
        end else begin
          r = want_state.pop_front();
          check_field("playing", res_word.playing, r.playing);
          check_field("cur_clip", res_word.cur_clip, r.cur_clip);
          check_field("cur_frame", res_word.cur_frame, r.cur_frame);
          check_field("cur_phase", res_word.cur_phase, r.cur_phase);
          check_field("next_active", res_word.next_active, r.next_active);
          check_field("next_clip", res_word.next_clip, r.next_clip);
          check_field("next_frame", res_word.next_frame, r.next_frame);
          check_field("next_phase", res_word.next_phase, r.next_phase);
          check_field("blend_progress", res_word.blend_progress, r.blend_progress);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        sequence_cmd(cmd_word, r);
        queue_state(r);
      end
    end
  end

  // Command driver: bursts of words separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (cmd_fifo.size() > 0) begin
        cmd_valid <= 1'b1;
        cmd_word <= cmd_fifo.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result stall: switch to a random stall pattern whenever the 7-bit rx_count wraps
  rx_mode_t rx_mode = RX_OPEN;
  logic [6:0] rx_count = '0;

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      rx_count <= rx_count + 1'b1;
      if (rx_count == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   res_stall <= 1'b0;
        RX_RANDOM: res_stall <= ($urandom_range(0, 2) == 0);
        RX_COMB:   res_stall <= (rx_count[2:0] < 3'd3);
        default:   res_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic cmd_word_t pack_cmd(input cmd_t op, input int c, input int spd,
                                         input int bt, input int fc, input int fr);
    cmd_word_t w;
    w.command = op;
    w.clip_index = CLIP_W'(c);
    w.speed_scale = SPEED_W'(spd);
    w.blend_time = TIME_W'(bt);
    w.frame_count = FRAME_BITS'(fc);
    w.frame_rate = RATE_W'(fr);
    return w;
  endfunction

  function automatic cmd_word_t filler_cmd(input cmd_t op);
    return pack_cmd(op, $urandom_range(0, 15), $urandom_range(0, 2560),
                    $urandom_range(0, 65535), $urandom_range(0, 1023),
                    $urandom_range(0, 65535));
  endfunction

  // Wait until every queued word is taken and answered, then let the block settle
  task automatic drain_words();
    while (cmd_fifo.size() > 0 || cmd_valid || want_state.size() > 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Write the tick length register: setup cycle, then access cycle
  task automatic write_tick(input logic [TICK_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_TICK, 2'b00};
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tick_len = v;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned tick_set[5];
    bit loaded[NUM_CLIPS];
    int loaded_ids[$];
    int k, c, fc, fr, spd, bt;
    tick_set = '{65535, 1, 9000, 0, 65535};
    tick_set[3] = $urandom_range(2, 65534);
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset tick length
    queue_cmd(filler_cmd(CMD_TICK));
    queue_cmd(filler_cmd(CMD_NOP));
    queue_cmd(pack_cmd(CMD_LOAD, 0, 0, 0, 0, 65535));
    queue_cmd(pack_cmd(CMD_LOAD, 15, 2560, 65535, 1023, 0));
    queue_cmd(pack_cmd(CMD_LOAD, 5, 0, 0, 1, 65535));
    queue_cmd(pack_cmd(CMD_LOAD, 9, 0, 0, 2, 32768));
    queue_cmd(pack_cmd(CMD_LOAD, 3, 0, 0, 3, 65535));
    queue_cmd(filler_cmd(CMD_TICK));
    queue_cmd(pack_cmd(CMD_PLAY, 15, 2560, 0, 0, 0));
    queue_cmd(pack_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    queue_cmd(pack_cmd(CMD_PLAY, 3, 2560, 1, 1023, 65535));
    queue_cmd(pack_cmd(CMD_TICK, 15, 2560, 65535, 1023, 65535));
    queue_cmd(pack_cmd(CMD_PLAY, 5, 0, 65535, 0, 0));
    repeat (3) queue_cmd(filler_cmd(CMD_TICK));
    queue_cmd(pack_cmd(CMD_PLAY, 9, 2048, 300, 0, 0));
    repeat (2) queue_cmd(filler_cmd(CMD_TICK));
    queue_cmd(pack_cmd(CMD_PLAY, 0, 2560, 0, 0, 0));
    queue_cmd(filler_cmd(CMD_TICK));
    queue_cmd(filler_cmd(CMD_NOP));
    foreach (loaded_ids[i]) loaded[loaded_ids[i]] = 1'b1;
    loaded_ids = '{0, 15, 5, 9, 3};
    foreach (loaded_ids[i]) loaded[loaded_ids[i]] = 1'b1;
    drain_words();

    // Random words under each tick length, mostly ticks between loads and plays
    foreach (tick_set[p]) begin
      write_tick(TICK_W'(tick_set[p]));
      n_settings++;
      for (int n = 0; n < WORDS_PER_SETTING; n++) begin
        k = $urandom_range(0, 99);
        if (k < 10) begin
          c = $urandom_range(0, 15);
          if ($urandom_range(0, 9) < 4) fc = $urandom_range(0, 4);
          else if ($urandom_range(0, 2) == 0) fc = $urandom_range(5, 20);
          else fc = $urandom_range(0, 1023);
          fr = ($urandom_range(0, 1) == 0) ? $urandom_range(49152, 65535)
                                           : $urandom_range(0, 65535);
          queue_cmd(pack_cmd(CMD_LOAD, c, $urandom_range(0, 2560),
                             $urandom_range(0, 65535), fc, fr));
          if (!loaded[c]) begin
            loaded[c] = 1'b1;
            loaded_ids.insert(loaded_ids.size(), c);
          end
        end else if (k < 22) begin
          c = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
          spd = ($urandom_range(0, 4) < 2) ? $urandom_range(2048, 2560)
                                           : $urandom_range(0, 2560);
          k = $urandom_range(0, 9);
          if (k < 2) begin
            bt = 0;
          end else if (k < 6) begin
            // aim for a cross-fade lasting a few dozen ticks at most
            bt = (tick_set[p] * $urandom_range(1, 40)) / 256;
            if (bt < 1) bt = 1;
            if (bt > 65535) bt = 65535;
          end else begin
            bt = $urandom_range(1, 65535);
          end
          queue_cmd(pack_cmd(CMD_PLAY, c, spd, bt, $urandom_range(0, 1023),
                             $urandom_range(0, 65535)));
        end else if (k < 97) begin
          queue_cmd(filler_cmd(CMD_TICK));
        end else begin
          queue_cmd(filler_cmd(CMD_NOP));
        end
      end
      drain_words();
    end

    repeat (40) @(negedge clk);
    $display("Covered %0d loads, %0d plays, %0d ticks and %0d no-op words over %0d tick lengths",
             n_load, n_play, n_tick, n_other, n_settings);
    $display("Checked %0d frame advances and %0d finished cross-fades", n_frame_steps,
             n_blends);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    #4000000;
    $display("Timeout: %0d words queued, %0d results outstanding", cmd_fifo.size(),
             want_state.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/afs_pkg.sv
rtl/afs_ram.sv
rtl/animation_frame_sequencer.sv
tb/tb_top.sv
